### sv/pps_pkg.sv
package pps_pkg;

  // Image and mode limits
  localparam int IMG_WIDTH = 640;
  localparam int MAX_SCALE = 8;

  // Field widths
  localparam int IDX_W   = 4;
  localparam int ROW_W   = 9;
  localparam int COL_W   = 10;
  localparam int COLOR_W = 32;
  localparam int ADDR_W  = 24;
  localparam int CFG_W   = 5;

  // Palette store
  localparam int PAL_DEPTH = 16;

  // Scale factor and replication counter widths
  localparam int FAC_W = $clog2(MAX_SCALE + 1);
  localparam int CNT_W = $clog2(MAX_SCALE);

  // Reciprocal multiply: floor(x / f) = (x * recip(f)) >> RECIP_SH,
  // exact for x below 2^19 and f up to 8
  localparam int RECIP_SH = 22;
  localparam int RECIP_W  = 22;
  localparam int MUL_W    = 32;

  // Payload packing
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 56;

  // Request kinds carried in tuser
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // ceil(2^RECIP_SH / f) for the shrink factors
  function automatic logic [RECIP_W-1:0] recip(input logic [FAC_W-1:0] f);
    logic [RECIP_W-1:0] r;
    begin
      case (f)
        4'd2:    r = 22'd2097152;
        4'd3:    r = 22'd1398102;
        4'd4:    r = 22'd1048576;
        4'd5:    r = 22'd838861;
        4'd6:    r = 22'd699051;
        4'd7:    r = 22'd599187;
        4'd8:    r = 22'd524288;
        default: r = 22'd0;
      endcase
      return r;
    end
  endfunction

endpackage

### sv/pps_ram.sv
module pps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/palette_pixel_scaler_top.sv
// Palette pixel scaler. Each pixel request carries a 4-bit palette index and its
// source row and column; the block looks the index up in a 16-entry RGBA palette
// and emits color words with flat destination addresses. A palette-write request
// loads one entry and produces no output. The scale register picks the mode:
// 2..8 magnifies (scale*scale results per pixel, rows outer, columns inner),
// -2..-8 shrinks (only pixels on multiples of the factor are kept), and -1, 0, 1
// copy one to one; values beyond +/-8 saturate. Requests are taken one per cycle
// in copy and shrink modes while the result side keeps up. In magnify mode a pixel
// holds the output register until all scale*scale results are taken, one result per
// accepted cycle, and input is stalled meanwhile. A pixel passes through the
// palette RAM read alongside the first multiplier stage, the second multiplier
// stage and the address add before its first result. A palette entry written
// by one request is seen by a pixel in the very next cycle. Reading an entry that
// was never written returns an undefined color. Write scale only while the block
// is idle.
module palette_pixel_scaler_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration
  input  logic                              cfg_we_i,
  input  logic [pps_pkg::CFG_W-1:0]         cfg_wdata_i,     // scale, signed
  // Request stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [3:0] pixel_index, [12:4] row, [22:13] col, [54:23] color_in, [55] zero
  input  logic [pps_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input  logic                              s_axis_tuser,    // action
  // Result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [23:0] address, [55:24] color
  output logic [pps_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                              m_axis_tlast
);

  localparam int FAC_W   = pps_pkg::FAC_W;
  localparam int CNT_W   = pps_pkg::CNT_W;
  localparam int ROW_W   = pps_pkg::ROW_W;
  localparam int COL_W   = pps_pkg::COL_W;
  localparam int IDX_W   = pps_pkg::IDX_W;
  localparam int COLOR_W = pps_pkg::COLOR_W;
  localparam int ADDR_W  = pps_pkg::ADDR_W;
  localparam int RECIP_W = pps_pkg::RECIP_W;
  localparam int MUL_W   = pps_pkg::MUL_W;
  localparam int SH      = pps_pkg::RECIP_SH;
  localparam int A_W     = 13;

  // Request fields
  logic [IDX_W-1:0]   in_idx;
  logic [ROW_W-1:0]   in_row;
  logic [COL_W-1:0]   in_col;
  logic [COLOR_W-1:0] in_color;

  assign in_idx   = s_axis_tdata[3:0];
  assign in_row   = s_axis_tdata[12:4];
  assign in_col   = s_axis_tdata[22:13];
  assign in_color = s_axis_tdata[54:23];

  // ---------------------------------------------------------------------------
  // Mode registers, decoded at configuration time
  // ---------------------------------------------------------------------------
  logic               shr_q, shr_d;
  logic [FAC_W-1:0]   fac_q, fac_d;
  logic [RECIP_W-1:0] op1_q, op1_d;
  logic [MUL_W-1:0]   mul_q, mul_d;
  logic [CNT_W-1:0]   m1_q, m1_d;
  logic [ADDR_W-1:0]  jump_q, jump_d;

  logic signed [pps_pkg::CFG_W-1:0] cfg_s;
  logic [pps_pkg::CFG_W-1:0]        cfg_abs;
  logic [RECIP_W-1:0]               cfg_rec;
  logic [MUL_W-1:0]                 cfg_stride;

  always_comb begin
    cfg_s   = signed'(cfg_wdata_i);
    cfg_abs = cfg_s[pps_pkg::CFG_W-1] ? pps_pkg::CFG_W'(-cfg_s) : pps_pkg::CFG_W'(cfg_s);
    if (cfg_abs <= 5'd1) begin
      fac_d = FAC_W'(1);
      shr_d = 1'b0;
    end else begin
      fac_d = (cfg_abs > 5'(pps_pkg::MAX_SCALE)) ? FAC_W'(pps_pkg::MAX_SCALE)
                                                 : cfg_abs[FAC_W-1:0];
      shr_d = cfg_s[pps_pkg::CFG_W-1];
    end
    cfg_rec    = pps_pkg::recip(fac_d);
    cfg_stride = MUL_W'(pps_pkg::IMG_WIDTH) * MUL_W'(fac_d);
    op1_d  = shr_d ? cfg_rec : RECIP_W'(fac_d);
    mul_d  = shr_d ? MUL_W'(MUL_W'(pps_pkg::IMG_WIDTH) * MUL_W'(cfg_rec)) : cfg_stride;
    m1_d   = shr_d ? '0 : CNT_W'(fac_d - FAC_W'(1));
    jump_d = ADDR_W'(cfg_stride) - ADDR_W'(fac_d) + ADDR_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shr_q  <= 1'b0;
      fac_q  <= FAC_W'(1);
      op1_q  <= RECIP_W'(1);
      mul_q  <= MUL_W'(pps_pkg::IMG_WIDTH);
      m1_q   <= '0;
      jump_q <= ADDR_W'(pps_pkg::IMG_WIDTH);
    end else if (cfg_we_i) begin
      shr_q  <= shr_d;
      fac_q  <= fac_d;
      op1_q  <= op1_d;
      mul_q  <= mul_d;
      m1_q   <= m1_d;
      jump_q <= jump_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: every stage moves when the output stage can take more
  // ---------------------------------------------------------------------------
  logic g_valid_q;
  logic g_last;
  logic adv;
  logic in_acc;

  assign adv           = !g_valid_q || (m_axis_tready && g_last);
  assign s_axis_tready = adv;
  assign in_acc        = s_axis_tvalid && adv;

  // Palette RAM: written by write requests, read by pixel requests
  logic [COLOR_W-1:0] pal_rdata;

  pps_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (pps_pkg::PAL_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (in_acc && (s_axis_tuser == pps_pkg::ACT_WRITE)),
    .waddr_i (in_idx),
    .wdata_i (in_color),
    .re_i    (in_acc && (s_axis_tuser == pps_pkg::ACT_PIXEL)),
    .raddr_i (in_idx),
    .rdata_o (pal_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: palette read in flight, row/col scaled or divided
  // ---------------------------------------------------------------------------
  logic             s1_valid_q;
  logic [ROW_W-1:0] s1_row_q;
  logic [COL_W-1:0] s1_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_acc && (s_axis_tuser == pps_pkg::ACT_PIXEL);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_row_q <= in_row;
      s1_col_q <= in_col;
    end
  end

  logic [ROW_W+RECIP_W-1:0] s1_pr;
  logic [COL_W+RECIP_W-1:0] s1_pc;
  logic [A_W-1:0]           s2_a_d, s2_b_d;

  // Magnify: row*m, col*m. Shrink: row/f, col/f by reciprocal
  always_comb begin
    s1_pr  = (ROW_W+RECIP_W)'(s1_row_q) * (ROW_W+RECIP_W)'(op1_q);
    s1_pc  = (COL_W+RECIP_W)'(s1_col_q) * (COL_W+RECIP_W)'(op1_q);
    s2_a_d = shr_q ? A_W'(s1_pr[ROW_W+RECIP_W-1:SH]) : s1_pr[A_W-1:0];
    s2_b_d = shr_q ? A_W'(s1_pc[COL_W+RECIP_W-1:SH]) : s1_pc[A_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // Stage 2: row base times stride (or rq*640/f), divisibility check
  // ---------------------------------------------------------------------------
  logic               s2_valid_q;
  logic [A_W-1:0]     s2_a_q, s2_b_q;
  logic [ROW_W-1:0]   s2_row_q;
  logic [COL_W-1:0]   s2_col_q;
  logic [COLOR_W-1:0] s2_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_a_q     <= s2_a_d;
      s2_b_q     <= s2_b_d;
      s2_row_q   <= s1_row_q;
      s2_col_q   <= s1_col_q;
      s2_color_q <= pal_rdata;
    end
  end

  logic [A_W+MUL_W-1:0] s2_p;
  logic [ADDR_W-1:0]    s3_p_d;
  logic [A_W+FAC_W-1:0] s2_rchk, s2_cchk;
  logic                 s3_keep_d;

  always_comb begin
    s2_p      = (A_W+MUL_W)'(s2_a_q) * (A_W+MUL_W)'(mul_q);
    s3_p_d    = shr_q ? ADDR_W'(s2_p[A_W+MUL_W-1:SH]) : s2_p[ADDR_W-1:0];
    s2_rchk   = (A_W+FAC_W)'(s2_a_q) * (A_W+FAC_W)'(fac_q);
    s2_cchk   = (A_W+FAC_W)'(s2_b_q) * (A_W+FAC_W)'(fac_q);
    s3_keep_d = !shr_q || ((s2_rchk == (A_W+FAC_W)'(s2_row_q)) &&
                           (s2_cchk == (A_W+FAC_W)'(s2_col_q)));
  end

  // ---------------------------------------------------------------------------
  // Stage 3: add column part to get the first address
  // ---------------------------------------------------------------------------
  logic               s3_valid_q;
  logic [ADDR_W-1:0]  s3_p_q;
  logic [A_W-1:0]     s3_b_q;
  logic [COLOR_W-1:0] s3_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s3_valid_q <= s2_valid_q && s3_keep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_p_q     <= s3_p_d;
      s3_b_q     <= s2_b_q;
      s3_color_q <= s2_color_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: replicates the pixel over an m x m square
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0]  g_addr_q, g_addr_d;
  logic [COLOR_W-1:0] g_color_q;
  logic [CNT_W-1:0]   g_n_q, g_n_d, g_c_q, g_c_d;
  logic               g_valid_d;

  assign g_last = (g_n_q == m1_q) && (g_c_q == m1_q);

  always_comb begin
    g_valid_d = g_valid_q;
    g_addr_d  = g_addr_q;
    g_n_d     = g_n_q;
    g_c_d     = g_c_q;
    if (adv) begin
      g_valid_d = s3_valid_q;
      g_addr_d  = s3_p_q + ADDR_W'(s3_b_q);
      g_n_d     = '0;
      g_c_d     = '0;
    end else if (m_axis_tready) begin
      // Next column, or wrap to the start of the next destination row
      if (g_c_q == m1_q) begin
        g_c_d    = '0;
        g_n_d    = g_n_q + CNT_W'(1);
        g_addr_d = g_addr_q + jump_q;
      end else begin
        g_c_d    = g_c_q + CNT_W'(1);
        g_addr_d = g_addr_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_valid_q <= 1'b0;
      g_n_q     <= '0;
      g_c_q     <= '0;
    end else begin
      g_valid_q <= g_valid_d;
      g_n_q     <= g_n_d;
      g_c_q     <= g_c_d;
    end
  end

  always_ff @(posedge clk_i) begin
    g_addr_q <= g_addr_d;
    if (adv) begin
      g_color_q <= s3_color_q;
    end
  end

  assign m_axis_tvalid = g_valid_q;
  assign m_axis_tdata  = {g_color_q, g_addr_q};
  assign m_axis_tlast  = g_last;

endmodule

### dv/pps_result_check.sv
`timescale 1ns / 100ps

// Watches the request and result streams of the palette pixel scaler, keeps its
// own copy of the palette and the scale setting, predicts the color writes of
// every pixel request and compares each result with the oldest prediction.
module pps_result_check (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pps_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [pps_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                           s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [pps_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                           m_axis_tlast,
  output int                             err_cnt_o,
  output int                             pending_o
);

  localparam int ADDR_W  = pps_pkg::ADDR_W;
  localparam int COLOR_W = pps_pkg::COLOR_W;
  localparam int IDX_W   = pps_pkg::IDX_W;
  localparam int ROW_W   = pps_pkg::ROW_W;
  localparam int COL_W   = pps_pkg::COL_W;

  typedef struct packed {
    logic [ADDR_W-1:0]  address;
    logic [COLOR_W-1:0] color;
    logic               last;
  } px_write_t;

  px_write_t                        px_writes_q[$];
  logic [COLOR_W-1:0]               palette_mem [pps_pkg::PAL_DEPTH];
  logic signed [pps_pkg::CFG_W-1:0] scale_q;
  int                               err_cnt;
  int                               pending;

  assign err_cnt_o = err_cnt;
  assign pending_o = pending;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s mismatch, got 0x%0h, want 0x%0h", $time, what, got, want);
    err_cnt++;
  endtask

  // Color writes caused by one pixel under the current scale
  task automatic predict_pixel_writes(input logic [IDX_W-1:0] idx,
                                      input logic [ROW_W-1:0] row,
                                      input logic [COL_W-1:0] col);
    int          mode;
    int unsigned fac;
    int unsigned stride;
    int unsigned addr;
    int unsigned n;
    int unsigned c;
    px_write_t   w;
    mode = int'(scale_q);
    if (mode > pps_pkg::MAX_SCALE) mode = pps_pkg::MAX_SCALE;
    if (mode < -pps_pkg::MAX_SCALE) mode = -pps_pkg::MAX_SCALE;
    w.color = palette_mem[idx];
    if (mode > 1) begin
      // magnify: square of copies, destination rows outer
      fac = mode;
      stride = pps_pkg::IMG_WIDTH * fac;
      for (n = 0; n < fac; n++) begin
        for (c = 0; c < fac; c++) begin
          addr = (row * fac + n) * stride + col * fac + c;
          w.address = addr[ADDR_W-1:0];
          w.last = (n == fac - 1) && (c == fac - 1);
          px_writes_q.push_back(w);
        end
      end
    end else if (mode < -1) begin
      // shrink: keep only pixels on the factor grid
      fac = -mode;
      if ((row % fac) == 0 && (col % fac) == 0) begin
        addr = ((row / fac) * pps_pkg::IMG_WIDTH + col) / fac;
        w.address = addr[ADDR_W-1:0];
        w.last = 1'b1;
        px_writes_q.push_back(w);
      end
    end else begin
      addr = row * pps_pkg::IMG_WIDTH + col;
      w.address = addr[ADDR_W-1:0];
      w.last = 1'b1;
      px_writes_q.push_back(w);
    end
  endtask

  // Config tracking, result compare, then request prediction
  always @(posedge clk_i or negedge rst_ni) begin
    px_write_t want;
    if (!rst_ni) begin
      px_writes_q.delete();
      scale_q = 5'sd1;
      err_cnt = 0;
      pending = 0;
    end else begin
      if (cfg_we_i) scale_q = cfg_wdata_i;

      if (m_axis_tvalid && m_axis_tready) begin
        if (px_writes_q.size() == 0) begin
          report_mismatch("unexpected result, address", m_axis_tdata[ADDR_W-1:0], '0);
        end else begin
          want = px_writes_q.pop_front();
          if (m_axis_tdata[ADDR_W-1:0] !== want.address)
            report_mismatch("address", m_axis_tdata[ADDR_W-1:0], want.address);
          if (m_axis_tdata[ADDR_W +: COLOR_W] !== want.color)
            report_mismatch("color", m_axis_tdata[ADDR_W +: COLOR_W], want.color);
          if (m_axis_tlast !== want.last)
            report_mismatch("last", m_axis_tlast, want.last);
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == pps_pkg::ACT_WRITE)
          palette_mem[s_axis_tdata[IDX_W-1:0]] = s_axis_tdata[23 +: COLOR_W];
        else
          predict_pixel_writes(s_axis_tdata[IDX_W-1:0], s_axis_tdata[4 +: ROW_W],
                               s_axis_tdata[13 +: COL_W]);
      end

      pending = px_writes_q.size();
    end
  end

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int NUM_PHASES   = 15;
  localparam int PRESS_PHASE  = 8;
  localparam int HOLD_CYC     = 300;
  localparam int DRAIN_CYC    = 8;
  localparam int WD_LIMIT     = 4000;

  localparam int IDX_W   = pps_pkg::IDX_W;
  localparam int ROW_W   = pps_pkg::ROW_W;
  localparam int COL_W   = pps_pkg::COL_W;
  localparam int COLOR_W = pps_pkg::COLOR_W;
  localparam int CFG_W   = pps_pkg::CFG_W;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [CFG_W-1:0]               cfg_wdata_i;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [pps_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic                           s_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [pps_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           m_axis_tlast;

  int err_cnt;
  int pending;
  int src_idle_pct;
  int sink_stall_pct;
  int quiet_cyc;
  logic hold_req;
  logic hold_done;

  // scale and request count of each random phase
  int ph_scale [NUM_PHASES] = '{2, -2, 0, 3, -3, 15, -16, -1, 4, -5, 8, 1, 2, -4, -8};
  int ph_items [NUM_PHASES] = '{40, 40, 40, 35, 40, 10, 30, 30, 30, 35, 10, 50, 40, 40, 30};

  always #5 clk_i = ~clk_i;

  palette_pixel_scaler_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  pps_result_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .err_cnt_o    (err_cnt),
    .pending_o    (pending)
  );

  // Offer one request after random idle cycles; returns at the falling edge
  // after it was taken, with valid still high
  task automatic send_req(input logic act, input logic [IDX_W-1:0] idx,
                          input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                          input logic [COLOR_W-1:0] color);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {1'b0, color, col, row, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drop valid and let every predicted result come out
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYC) @(negedge clk_i);
  endtask

  task automatic write_scale(input logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    hold_done     = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYC) @(negedge clk_i);
        hold_done = 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Watchdog on cycles with no transfer on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cyc <= 0;
    else
      quiet_cyc <= quiet_cyc + 1;
    if (quiet_cyc >= WD_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    int                 i;
    int                 p;
    int                 k;
    int                 mode;
    int                 fac;
    logic [COLOR_W-1:0] color;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;

    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = pps_pkg::ACT_PIXEL;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_req       = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Fill the whole palette first so no pixel reads an unwritten entry
    for (i = 0; i < pps_pkg::PAL_DEPTH; i++) begin
      case (i)
        0:       color = 32'h0000_0000;
        1:       color = 32'hA5A5_A5A5;
        2:       color = 32'h5A5A_5A5A;
        15:      color = 32'hFFFF_FFFF;
        default: color = $urandom;
      endcase
      send_req(pps_pkg::ACT_WRITE, IDX_W'(i), ROW_W'($urandom), COL_W'($urandom), color);
    end

    // One-to-one copy at reset scale: corners, wrap, write then read next cycle
    send_req(pps_pkg::ACT_PIXEL, 4'd0, 9'd0, 10'd0, $urandom);
    send_req(pps_pkg::ACT_PIXEL, 4'd15, 9'd399, 10'd639, $urandom);
    send_req(pps_pkg::ACT_PIXEL, 4'd1, 9'd511, 10'd1023, $urandom);
    send_req(pps_pkg::ACT_WRITE, 4'd3, ROW_W'($urandom), COL_W'($urandom), 32'h1234_5678);
    send_req(pps_pkg::ACT_PIXEL, 4'd3, 9'd200, 10'd320, $urandom);
    wait_idle();

    // Largest magnify
    write_scale(CFG_W'(pps_pkg::MAX_SCALE));
    send_req(pps_pkg::ACT_PIXEL, 4'd2, 9'd399, 10'd639, $urandom);
    send_req(pps_pkg::ACT_PIXEL, 4'd0, 9'd511, 10'd1023, $urandom);
    wait_idle();

    // Largest shrink: kept and dropped pixels
    write_scale(CFG_W'(-pps_pkg::MAX_SCALE));
    send_req(pps_pkg::ACT_PIXEL, 4'd15, 9'd0, 10'd0, $urandom);
    send_req(pps_pkg::ACT_PIXEL, 4'd4, 9'd8, 10'd16, $urandom);
    send_req(pps_pkg::ACT_PIXEL, 4'd5, 9'd3, 10'd0, $urandom);
    send_req(pps_pkg::ACT_PIXEL, 4'd6, 9'd399, 10'd632, $urandom);
    send_req(pps_pkg::ACT_PIXEL, 4'd7, 9'd392, 10'd632, $urandom);
    wait_idle();

    // Random phases over scale settings and idle patterns
    for (p = 0; p < NUM_PHASES; p++) begin
      write_scale(CFG_W'(ph_scale[p]));
      case (p % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 45; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 45; end
        default: begin src_idle_pct = 12; sink_stall_pct = 12; end
      endcase
      if (p == PRESS_PHASE) hold_req = 1'b1;
      mode = ph_scale[p];
      if (mode > pps_pkg::MAX_SCALE) mode = pps_pkg::MAX_SCALE;
      if (mode < -pps_pkg::MAX_SCALE) mode = -pps_pkg::MAX_SCALE;
      fac = (mode < -1) ? -mode : 1;

      for (k = 0; k < ph_items[p]; k++) begin
        if ($urandom_range(99) < 10) begin
          send_req(pps_pkg::ACT_WRITE, IDX_W'($urandom), ROW_W'($urandom),
                   COL_W'($urandom), $urandom);
        end else begin
          if (fac > 1 && $urandom_range(99) < 65) begin
            // on the shrink grid, so most pixels survive
            row = ROW_W'(fac * $urandom_range(0, 399 / fac));
            col = COL_W'(fac * $urandom_range(0, 639 / fac));
          end else if ($urandom_range(99) < 85) begin
            row = ROW_W'($urandom_range(0, 399));
            col = COL_W'($urandom_range(0, 639));
          end else begin
            row = ROW_W'($urandom);
            col = COL_W'($urandom);
          end
          send_req(pps_pkg::ACT_PIXEL, IDX_W'($urandom), row, col, $urandom);
        end
      end
      wait_idle();
    end

    if (err_cnt == 0 && pending == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
